FILE: hdl/mste_pkg.sv
// Shared constants, types, sine table and saturation helper for the matrix stack engine.
package mste_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int STACK_DEPTH  = 20;
  localparam int QUARTER_TURN = 900;
  localparam int HALF_TURN    = 1800;
  localparam int FULL_TURN    = 3600;
  localparam int TAYLOR_TERMS = 12;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam int ACC_W   = 64 - FRAC_BITS + 2;
  localparam int STK_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH * 16);
  localparam int ROM_AW  = $clog2(QUARTER_TURN + 1);
  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    REQ_SCALE     = 3'd0,
    REQ_TRANSLATE = 3'd1,
    REQ_ROTATE    = 3'd2,
    REQ_SWAP      = 3'd3,
    REQ_PUSH      = 3'd4,
    REQ_POP       = 3'd5,
    REQ_POINT     = 3'd6,
    REQ_NONE      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2,
    STS_RSVD      = 2'd3
  } sts_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Operand and tag that travel down the row of cells.
  typedef struct packed {
    logic               vld;
    logic               xfm;
    logic               first;
    logic               last;
    logic [1:0]         row;
    logic [1:0]         kk;
    logic signed [31:0] opd;
  } link_t;

  typedef logic [FRAC_BITS:0] sine_rom_t [0:QUARTER_TURN];

  function automatic sine_rom_t build_sine();
    sine_rom_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] s;
    for (int u = 0; u <= QUARTER_TURN; u++) begin
      x   = (64'(u) * PI_Q30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
      x2  = (x * x) >> 30;
      mag = x;
      s   = $signed(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - $signed(mag);
        else s = s + $signed(mag);
      end
      if (s < 0) s = 0;
      q = ($unsigned(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
      tab[u] = q[FRAC_BITS:0];
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) r = v[31:0];
    else if (v[ACC_W-1]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

FILE: hdl/mste_cell.sv
// One column cell: holds a matrix column, multiplies the passing operand and accumulates.
module mste_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             col_idx,
  input  mste_pkg::link_t        link_in,
  output mste_pkg::link_t        link_out,
  input  logic                   d_load,
  input  logic [3:0][31:0]       d_col,
  input  logic                   wr_en,
  input  logic [1:0]             wr_row,
  input  logic signed [31:0]     wr_data,
  input  logic [1:0]             rd_row,
  output logic signed [31:0]     rd_data,
  output logic signed [31:0]     res_out
);

  logic signed [31:0]                  m_r [4];
  logic signed [31:0]                  d_r [4];
  logic signed [63:0]                  prod_r;
  mste_pkg::link_t                     link_r;
  mste_pkg::link_t                     pl_r;
  logic signed [mste_pkg::ACC_W-1:0]   acc_r;
  logic signed [31:0]                  res_r;

  logic [1:0]                          m_sel;
  logic signed [31:0]                  m_val;
  logic signed [31:0]                  mul_b;
  logic signed [63:0]                  rnd_h;
  logic signed [mste_pkg::ACC_W-1:0]   rnd_v;
  logic signed [mste_pkg::ACC_W-1:0]   sum;

  assign m_sel = (link_in.vld && link_in.xfm) ? link_in.kk : rd_row;
  assign m_val = m_r[m_sel];
  assign mul_b = link_in.xfm ? m_val : d_r[link_in.kk];
  assign rd_data = m_val;

  assign rnd_h = prod_r + (64'sd1 <<< (mste_pkg::FRAC_BITS - 1));
  assign rnd_v = mste_pkg::ACC_W'(rnd_h >>> mste_pkg::FRAC_BITS);
  assign sum   = (pl_r.first ? '0 : acc_r) + rnd_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        m_r[i] <= (2'(i) == col_idx) ? mste_pkg::Q_ONE : '0;
      end
      link_r <= '0;
      pl_r   <= '0;
    end else begin
      link_r <= link_in;
      pl_r   <= link_in;
      if (pl_r.vld && pl_r.last && !pl_r.xfm) begin
        m_r[pl_r.row] <= mste_pkg::sat32(sum);
      end
      if (wr_en) begin
        m_r[wr_row] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.vld) begin
      prod_r <= link_in.opd * mul_b;
    end
    if (d_load) begin
      for (int k = 0; k < 4; k++) begin
        d_r[k] <= d_col[k];
      end
    end
    if (pl_r.vld) begin
      acc_r <= sum;
      if (pl_r.last && pl_r.xfm) begin
        res_r <= mste_pkg::sat32(sum);
      end
    end
  end

  assign link_out = link_r;
  assign res_out  = res_r;

endmodule

FILE: hdl/matrix_stack_transform_engine_unit.sv
// Top level of the matrix stack engine: command sequencer, sine lookup, stack memory and cells.
// A matrix update streams 16 row elements through a chain of four column cells, one
// multiply per cell per cycle, then drains the chain before the result; a rotation first
// reduces the angle and looks up sine and cosine. A point transform streams its four
// operands through the same chain; push and pop move the matrix through the stack memory
// one word per cycle.
// One transaction is processed at a time; a new one is taken once the previous result
// sits in the output register.
module matrix_stack_transform_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [15:0] in_angle_tenths,
  input  logic [1:0]         in_rot_axis,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic [1:0]         out_status
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_ANG   = 12'b0000_0000_0010,
    ST_TRIG0 = 12'b0000_0000_0100,
    ST_TRIG1 = 12'b0000_0000_1000,
    ST_TRIG2 = 12'b0000_0001_0000,
    ST_LOAD  = 12'b0000_0010_0000,
    ST_MUL   = 12'b0000_0100_0000,
    ST_XFM   = 12'b0000_1000_0000,
    ST_DRAIN = 12'b0001_0000_0000,
    ST_PUSH  = 12'b0010_0000_0000,
    ST_POP   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

  localparam logic [2:0] DRAIN_LAST = 3'd4;

  state_t                            state_r;
  mste_pkg::req_t                    cmd_r;
  mste_pkg::axis_t                   axis_r;
  mste_pkg::sts_t                    sts_r;
  logic signed [31:0]                x_r, y_r, z_r;
  logic signed [16:0]                a_r;
  logic                              sneg_r, cneg_r;
  logic signed [31:0]                s_r, c_r;
  logic [3:0]                        cnt_r;
  logic [2:0]                        dcnt_r;
  logic [mste_pkg::STK_W-1:0]        stk_r;
  mste_pkg::link_t                   link0_r;
  logic [mste_pkg::FRAC_BITS:0]      rom_q_r;
  logic [31:0]                       mem_q_r;
  logic                              pw_vld_r;
  logic [3:0]                        pw_idx_r;
  logic                              out_valid_r;
  logic signed [31:0]                ox_r, oy_r, oz_r, ow_r;
  logic [1:0]                        osts_r;

  logic [31:0]                       mem [0:mste_pkg::STACK_DEPTH*16-1];

  mste_pkg::link_t                   links [5];
  logic signed [31:0]                cell_rd  [4];
  logic signed [31:0]                cell_res [4];
  logic [3:0][31:0]                  cell_dcol [4];
  logic signed [3:0][3:0][31:0]      d_mat;
  logic                              d_load;
  logic [10:0]                       sin_map, cos_map;
  logic [12:0]                       cos_ang;
  logic [mste_pkg::ROM_AW-1:0]       rom_addr;
  logic [mste_pkg::STK_W+3:0]        addr_full;
  logic [mste_pkg::ADDR_W-1:0]       mem_addr;
  logic                              mem_we;
  logic signed [31:0]                pt_opd;
  logic signed [31:0]                rom_sval;
  logic                              accept;
  logic                              out_free;

  function automatic logic [10:0] quad_map(input logic [11:0] a);
    logic [10:0] r;
    if (a <= 12'(mste_pkg::QUARTER_TURN)) begin
      r = {1'b0, a[9:0]};
    end else if (a <= 12'(mste_pkg::HALF_TURN)) begin
      r = {1'b0, 10'(12'(mste_pkg::HALF_TURN) - a)};
    end else if (a <= 12'(mste_pkg::HALF_TURN + mste_pkg::QUARTER_TURN)) begin
      r = {1'b1, 10'(a - 12'(mste_pkg::HALF_TURN))};
    end else begin
      r = {1'b1, 10'(12'(mste_pkg::FULL_TURN) - a)};
    end
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cos_ang  = (13'(a_r[11:0]) + 13'(mste_pkg::QUARTER_TURN) >= 13'(mste_pkg::FULL_TURN))
                  ? 13'(a_r[11:0]) + 13'(mste_pkg::QUARTER_TURN) - 13'(mste_pkg::FULL_TURN)
                  : 13'(a_r[11:0]) + 13'(mste_pkg::QUARTER_TURN);
  assign sin_map  = quad_map(a_r[11:0]);
  assign cos_map  = quad_map(cos_ang[11:0]);
  assign rom_addr = (state_r == ST_TRIG0) ? sin_map[9:0] : cos_map[9:0];
  assign rom_sval = 32'(rom_q_r);

  assign addr_full = {stk_r, cnt_r};
  assign mem_addr  = addr_full[mste_pkg::ADDR_W-1:0];
  assign mem_we    = (state_r == ST_PUSH);
  assign d_load    = (state_r == ST_LOAD);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pt_opd = x_r;
      2'd1:    pt_opd = y_r;
      2'd2:    pt_opd = z_r;
      default: pt_opd = mste_pkg::Q_ONE;
    endcase
  end

  always_comb begin
    d_mat = '0;
    for (int i = 0; i < 4; i++) begin
      d_mat[i][i] = mste_pkg::Q_ONE;
    end
    unique case (cmd_r)
      mste_pkg::REQ_SCALE: begin
        d_mat[0][0] = x_r;
        d_mat[1][1] = y_r;
        d_mat[2][2] = z_r;
      end
      mste_pkg::REQ_TRANSLATE: begin
        d_mat[3][0] = x_r;
        d_mat[3][1] = y_r;
        d_mat[3][2] = z_r;
      end
      mste_pkg::REQ_ROTATE: begin
        unique case (axis_r)
          mste_pkg::AXIS_X: begin
            d_mat[1][1] = c_r;
            d_mat[1][2] = s_r;
            d_mat[2][1] = -s_r;
            d_mat[2][2] = c_r;
          end
          mste_pkg::AXIS_Y: begin
            d_mat[0][0] = c_r;
            d_mat[0][2] = -s_r;
            d_mat[2][0] = s_r;
            d_mat[2][2] = c_r;
          end
          mste_pkg::AXIS_Z: begin
            d_mat[0][0] = c_r;
            d_mat[0][1] = s_r;
            d_mat[1][0] = -s_r;
            d_mat[1][1] = c_r;
          end
          default: begin
          end
        endcase
      end
      mste_pkg::REQ_SWAP: begin
        d_mat = '0;
        d_mat[0][1] = mste_pkg::Q_ONE;
        d_mat[1][0] = mste_pkg::Q_ONE;
        d_mat[2][2] = mste_pkg::Q_ONE;
        d_mat[3][3] = mste_pkg::Q_ONE;
      end
      default: begin
      end
    endcase
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        cell_dcol[j][k] = d_mat[k][j];
      end
    end
  end

  assign links[0] = link0_r;

  for (genvar j = 0; j < 4; j++) begin : g_cell
    mste_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .col_idx  (2'(j)),
      .link_in  (links[j]),
      .link_out (links[j+1]),
      .d_load   (d_load),
      .d_col    (cell_dcol[j]),
      .wr_en    (pw_vld_r && (pw_idx_r[1:0] == 2'(j))),
      .wr_row   (pw_idx_r[3:2]),
      .wr_data  ($signed(mem_q_r)),
      .rd_row   (cnt_r[3:2]),
      .rd_data  (cell_rd[j]),
      .res_out  (cell_res[j])
    );
  end

  always_ff @(posedge clk) begin
    rom_q_r <= mste_pkg::SINE_ROM[rom_addr];
    if (mem_we) begin
      mem[mem_addr] <= cell_rd[cnt_r[1:0]];
    end
    mem_q_r  <= mem[mem_addr];
    pw_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stk_r       <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      link0_r     <= '0;
      pw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sts_r       <= mste_pkg::STS_OK;
    end else begin
      pw_vld_r <= (state_r == ST_POP);
      if (state_r == ST_MUL || state_r == ST_XFM) begin
        link0_r <= '{vld: 1'b1, xfm: (state_r == ST_XFM), first: (cnt_r[1:0] == 2'd0),
                     last: (cnt_r[1:0] == 2'd3),
                     row: (state_r == ST_XFM) ? 2'd0 : cnt_r[3:2], kk: cnt_r[1:0],
                     opd: (state_r == ST_XFM) ? pt_opd : cell_rd[cnt_r[1:0]]};
      end else begin
        link0_r <= '0;
      end
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r  <= '0;
          dcnt_r <= '0;
          if (accept) begin
            cmd_r  <= mste_pkg::req_t'(in_req_type);
            axis_r <= mste_pkg::axis_t'(in_rot_axis);
            x_r    <= in_x;
            y_r    <= in_y;
            z_r    <= in_z;
            a_r    <= 17'(in_angle_tenths);
            case (mste_pkg::req_t'(in_req_type))
              mste_pkg::REQ_SCALE, mste_pkg::REQ_TRANSLATE, mste_pkg::REQ_SWAP: begin
                sts_r   <= mste_pkg::STS_OK;
                state_r <= ST_LOAD;
              end
              mste_pkg::REQ_ROTATE: begin
                sts_r   <= mste_pkg::STS_OK;
                state_r <= (mste_pkg::axis_t'(in_rot_axis) == mste_pkg::AXIS_NONE)
                         ? ST_DONE : ST_ANG;
              end
              mste_pkg::REQ_PUSH: begin
                if (stk_r >= mste_pkg::STK_W'(mste_pkg::STACK_DEPTH)) begin
                  sts_r   <= mste_pkg::STS_OVERFLOW;
                  state_r <= ST_DONE;
                end else begin
                  sts_r   <= mste_pkg::STS_OK;
                  state_r <= ST_PUSH;
                end
              end
              mste_pkg::REQ_POP: begin
                if (stk_r == '0) begin
                  sts_r   <= mste_pkg::STS_UNDERFLOW;
                  state_r <= ST_DONE;
                end else begin
                  sts_r   <= mste_pkg::STS_OK;
                  stk_r   <= stk_r - 1'b1;
                  state_r <= ST_POP;
                end
              end
              mste_pkg::REQ_POINT: begin
                sts_r   <= mste_pkg::STS_OK;
                state_r <= ST_XFM;
              end
              default: begin
                sts_r   <= mste_pkg::STS_OK;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_ANG: begin
          if (a_r < 0) begin
            a_r <= a_r + 17'(mste_pkg::FULL_TURN);
          end else if (a_r >= 17'(mste_pkg::FULL_TURN)) begin
            a_r <= a_r - 17'(mste_pkg::FULL_TURN);
          end else begin
            state_r <= ST_TRIG0;
          end
        end
        ST_TRIG0: begin
          sneg_r  <= sin_map[10];
          cneg_r  <= cos_map[10];
          state_r <= ST_TRIG1;
        end
        ST_TRIG1: begin
          s_r     <= sneg_r ? -rom_sval : rom_sval;
          state_r <= ST_TRIG2;
        end
        ST_TRIG2: begin
          c_r     <= cneg_r ? -rom_sval : rom_sval;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == 4'hf) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_XFM: begin
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r[1:0] == 2'd3) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DRAIN_LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_PUSH: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'hf) begin
            stk_r   <= stk_r + 1'b1;
            state_r <= ST_DONE;
          end
        end
        ST_POP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'hf) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            osts_r      <= sts_r;
            if (cmd_r == mste_pkg::REQ_POINT) begin
              ox_r <= cell_res[0];
              oy_r <= cell_res[1];
              oz_r <= cell_res[2];
              ow_r <= cell_res[3];
            end else begin
              ox_r <= '0;
              oy_r <= '0;
              oz_r <= '0;
              ow_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;
  assign out_w      = ow_r;
  assign out_status = osts_r;

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_r <= mste_pkg::STK_W'(mste_pkg::STACK_DEPTH))
    else $error("Stack count exceeds its depth.");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == mste_pkg::REQ_PUSH
     && stk_r >= mste_pkg::STK_W'(mste_pkg::STACK_DEPTH))
    |=> (state_r == ST_DONE && sts_r == mste_pkg::STS_OVERFLOW && $stable(stk_r)))
    else $error("Push on a full stack was not rejected.");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == mste_pkg::REQ_POP && stk_r == '0)
    |=> (state_r == ST_DONE && sts_r == mste_pkg::STS_UNDERFLOW && stk_r == '0))
    else $error("Pop from an empty stack was not rejected.");

  a_link_busy: assert property (@(posedge clk) disable iff (!rst_n)
    links[4].vld |-> (state_r == ST_MUL || state_r == ST_XFM || state_r == ST_DRAIN))
    else $error("Cell chain active outside a multiply transaction.");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the matrix stack transform engine with a built-in predictor.
module tb;

  typedef struct {
    logic [2:0]         req;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] ang;
    logic [1:0]         axis;
  } cmd_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [1:0]         status;
  } point_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [15:0] in_angle_tenths;
  logic [1:0]         in_rot_axis;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic [1:0]         out_status;

  matrix_stack_transform_engine_unit uut (.*);

  cmd_t   pending_cmds[$];
  point_t expected_points[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     n_errors;

  logic signed [31:0] cur_mat[16];
  logic signed [31:0] saved_mats[mste_pkg::STACK_DEPTH][16];
  int                 depth_used;
  logic signed [31:0] quarter_sine[mste_pkg::QUARTER_TURN + 1];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void fill_sine();
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] s;
    for (int u = 0; u <= mste_pkg::QUARTER_TURN; u++) begin
      x = (64'(u) * 64'd3373259426 + 64'd900) / 64'd1800;
      x2 = (x * x) >> 30;
      mag = x;
      s = $signed(x);
      for (int n = 1; n <= 12; n++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - $signed(mag);
        else s = s + $signed(mag);
      end
      if (s < 0) s = 0;
      q = ($unsigned(s) + (64'd1 << 13)) >> 14;
      if (q > 64'd65536) q = 64'd65536;
      quarter_sine[u] = $signed(q[31:0]);
    end
  endfunction

  function automatic logic signed [31:0] sine_at(int a);
    if (a <= 900) return quarter_sine[a];
    if (a <= 1800) return quarter_sine[1800 - a];
    if (a <= 2700) return -quarter_sine[a - 1800];
    return -quarter_sine[3600 - a];
  endfunction

  // Rounds half up: floor(p / 2^16 + 1/2).
  function automatic longint q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void mul_into_current(logic signed [31:0] d[16]);
    logic signed [31:0] t[16];
    longint             acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += q_mul(cur_mat[i * 4 + k], d[k * 4 + j]);
        t[i * 4 + j] = clamp32(acc);
      end
    cur_mat = t;
  endfunction

  function automatic point_t predict_command(cmd_t c);
    point_t             r;
    logic signed [31:0] d[16];
    logic signed [31:0] sn;
    logic signed [31:0] cs;
    logic signed [31:0] p[4];
    longint             acc;
    int                 a;
    r = '{0, 0, 0, 0, mste_pkg::STS_OK};
    for (int i = 0; i < 16; i++) d[i] = (i % 5 == 0) ? mste_pkg::Q_ONE : 32'sd0;
    case (c.req)
      mste_pkg::REQ_SCALE: begin
        d[0] = c.x; d[5] = c.y; d[10] = c.z;
        mul_into_current(d);
      end
      mste_pkg::REQ_TRANSLATE: begin
        d[12] = c.x; d[13] = c.y; d[14] = c.z;
        mul_into_current(d);
      end
      mste_pkg::REQ_ROTATE: begin
        if (c.axis != mste_pkg::AXIS_NONE) begin
          a = ((int'(c.ang) % 3600) + 3600) % 3600;
          sn = sine_at(a);
          cs = sine_at((a + 900) % 3600);
          if (c.axis == mste_pkg::AXIS_X) begin
            d[5] = cs; d[6] = sn; d[9] = -sn; d[10] = cs;
          end else if (c.axis == mste_pkg::AXIS_Y) begin
            d[0] = cs; d[2] = -sn; d[8] = sn; d[10] = cs;
          end else begin
            d[0] = cs; d[1] = sn; d[4] = -sn; d[5] = cs;
          end
          mul_into_current(d);
        end
      end
      mste_pkg::REQ_SWAP: begin
        for (int i = 0; i < 16; i++) d[i] = 0;
        d[1] = mste_pkg::Q_ONE; d[4] = mste_pkg::Q_ONE;
        d[10] = mste_pkg::Q_ONE; d[15] = mste_pkg::Q_ONE;
        mul_into_current(d);
      end
      mste_pkg::REQ_PUSH: begin
        if (depth_used >= mste_pkg::STACK_DEPTH) r.status = mste_pkg::STS_OVERFLOW;
        else begin
          saved_mats[depth_used] = cur_mat;
          depth_used++;
        end
      end
      mste_pkg::REQ_POP: begin
        if (depth_used == 0) r.status = mste_pkg::STS_UNDERFLOW;
        else begin
          depth_used--;
          cur_mat = saved_mats[depth_used];
        end
      end
      mste_pkg::REQ_POINT: begin
        p[0] = c.x; p[1] = c.y; p[2] = c.z; p[3] = mste_pkg::Q_ONE;
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += q_mul(p[k], cur_mat[k * 4 + j]);
          case (j)
            0: r.x = clamp32(acc);
            1: r.y = clamp32(acc);
            2: r.z = clamp32(acc);
            default: r.w = clamp32(acc);
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] req, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [31:0] z,
                                    logic signed [15:0] ang, logic [1:0] axis);
    cmd_t c;
    c.req = req; c.x = x; c.y = y; c.z = z; c.ang = ang; c.axis = axis;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    c = make_cmd(3'($urandom_range(0, 7)), rand_q(), rand_q(), rand_q(),
                 16'($urandom), 2'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) c.req = mste_pkg::REQ_POINT;
    else if (pick < 45) c.req = mste_pkg::REQ_ROTATE;
    else if (pick < 55) c.req = mste_pkg::REQ_PUSH;
    else if (pick < 65) c.req = mste_pkg::REQ_POP;
    else if (pick < 75) c.req = mste_pkg::REQ_SCALE;
    if (c.req == mste_pkg::REQ_SCALE && $urandom_range(0, 3) != 0) begin
      c.x = $signed($urandom_range(32768, 98304));
      c.y = $signed($urandom_range(32768, 98304));
      c.z = $signed($urandom_range(32768, 98304));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        expected_points.push_back(predict_command(c));
        in_valid <= 1'b1;
        in_req_type <= c.req;
        in_x <= c.x;
        in_y <= c.y;
        in_z <= c.z;
        in_angle_tenths <= c.ang;
        in_rot_axis <= c.axis;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        point_t e;
        if (expected_points.size() == 0) begin
          $error("unexpected transaction");
          n_errors++;
        end else begin
          e = expected_points.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x); n_errors++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y); n_errors++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, out_z); n_errors++;
          end
          if (out_w !== e.w) begin
            $error("out_w expected %0d actual %0d", e.w, out_w); n_errors++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status); n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    fill_sine();
    cur_mat = '{default: 0};
    for (int i = 0; i < 4; i++) cur_mat[i * 5] = mste_pkg::Q_ONE;
    depth_used = 0;
    n_errors = 0;
    send_idle_pct = 31;
    recv_idle_pct = 62;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_req_type = mste_pkg::REQ_NONE;
    in_x = 0;
    in_y = 0;
    in_z = 0;
    in_angle_tenths = 0;
    in_rot_axis = mste_pkg::AXIS_NONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POP, 0, 0, 0, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POINT, 32'sh7fff_ffff, 32'sh8000_0000, -1,
                                    0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_NONE, 5, 6, 7, 8, mste_pkg::AXIS_Y));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_ROTATE, 0, 0, 0, 16'sh7fff,
                                    mste_pkg::AXIS_NONE));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_ROTATE, 0, 0, 0, 450, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_ROTATE, 0, 0, 0, 16'sh8000,
                                    mste_pkg::AXIS_Y));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_ROTATE, 0, 0, 0, 16'sh7fff,
                                    mste_pkg::AXIS_Z));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_ROTATE, 0, 0, 0, 3600, mste_pkg::AXIS_Z));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_SWAP, 0, 0, 0, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_PUSH, 0, 0, 0, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_TRANSLATE, 32'sh7fff_ffff, 32'sh8000_0000,
                                    65536, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POINT, 65536, -65536, 32'sh7fff_ffff, -1,
                                    mste_pkg::AXIS_Z));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_SCALE, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                                    0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                    32'sh7fff_ffff, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POP, 0, 0, 0, 0, mste_pkg::AXIS_X));
    for (int i = 0; i < mste_pkg::STACK_DEPTH + 1; i++)
      pending_cmds.push_back(make_cmd(mste_pkg::REQ_PUSH, 0, 0, 0, 0, mste_pkg::AXIS_X));
    pending_cmds.push_back(make_cmd(mste_pkg::REQ_POINT, 12345, -54321, 777, 0,
                                    mste_pkg::AXIS_X));
    for (int i = 0; i < mste_pkg::STACK_DEPTH + 1; i++)
      pending_cmds.push_back(make_cmd(mste_pkg::REQ_POP, 0, 0, 0, 0, mste_pkg::AXIS_X));

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 31;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < 267; i++) begin
        pending_cmds.push_back(rand_cmd());
        if (i == 130) begin
          wait_drained();
        end
      end
      wait_drained();
    end
    repeat (50) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hdl/mste_pkg.sv
hdl/mste_cell.sv
hdl/matrix_stack_transform_engine_unit.sv
tb/tb.sv
